// ===== rtl/fit_policy_block_allocator_macros.svh =====
// Assertion macros for the fit policy block allocator checker.
// Self-contained; the checker file includes this header.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define FPBA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked property that also holds across reset.
`define FPBA_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/fpba_pkg.sv =====
// Shared types and constants for the fit policy block allocator.
// No dependencies; imported by the controller, datapath and top level.
package fpba_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

    // Port field widths.
    localparam int ENTRY_IDX_W = 4;
    localparam int FIELD_SIZE_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    // Input opcodes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Placement rules.
    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_fit_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // write one table entry
        logic start;     // latch an allocate request and rewind the scan
        logic step;      // evaluate the current entry and advance
        logic out_load;  // publish the result and update the used flags
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero; // no entries to scan
        logic scan_done;  // current entry ends the scan
        logic out_free;   // output register can take a result
    } t_dp_sts;

endpackage

// ===== rtl/fit_policy_block_allocator.sv =====
// A load item writes one table entry when accepted. An allocate item is accepted, then scans
// the size table one entry per cycle through its registered read port, stopping at the first
// candidate under first fit and skipping a zero count, then waits for a free output register.
// The input stalls until the result is published; loads are taken every cycle while idle.
// Reset (synchronous, active low) frees every block, sets first fit and a
// full block count, and empties the output register; table contents persist.
module fit_policy_block_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [fpba_pkg::ENTRY_IDX_W-1:0]    i_entry_index,
    input  logic [fpba_pkg::FIELD_SIZE_W-1:0]   i_entry_size,
    input  logic [fpba_pkg::FIELD_SIZE_W-1:0]   i_request_size,
    input  logic                                i_end_of_pass,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_granted,
    output logic [fpba_pkg::ENTRY_IDX_W-1:0]    o_block_index,
    output logic [fpba_pkg::FIELD_SIZE_W-1:0]   o_block_size,
    output logic [fpba_pkg::FIELD_SIZE_W-1:0]   o_leftover,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpba_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    ready;

    // Configuration is always writable.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !ready;

    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_ready    (ready)
    );

    fpba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_entry_index  (i_entry_index),
        .i_entry_size   (i_entry_size),
        .i_request_size (i_request_size),
        .i_end_of_pass  (i_end_of_pass),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_granted      (o_granted),
        .o_block_index  (o_block_index),
        .o_block_size   (o_block_size),
        .o_leftover     (o_leftover)
    );

endmodule

// ===== rtl/fpba_ctrl.sv =====
// Sequencer for the fit policy block allocator: accept, scan, publish.
// Depends on fpba_pkg for the command and status structs.
module fpba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    input  fpba_pkg::t_dp_sts i_sts,
    output fpba_pkg::t_dp_cmd o_cmd,
    output logic              o_ready
);
    import fpba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_in_valid && o_ready;

    // Next state and command decode.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_ALLOC) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.count_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.scan_done) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/fpba_dp.sv =====
// Datapath for the fit policy block allocator: size table, used flags,
// scan pointer, best-candidate tracking and the output register. Uses fpba_pkg.
module fpba_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fpba_pkg::t_dp_cmd                   i_cmd,
    output fpba_pkg::t_dp_sts                   o_sts,
    input  logic                                i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [fpba_pkg::ENTRY_IDX_W-1:0]    i_entry_index,
    input  logic [fpba_pkg::FIELD_SIZE_W-1:0]   i_entry_size,
    input  logic [fpba_pkg::FIELD_SIZE_W-1:0]   i_request_size,
    input  logic                                i_end_of_pass,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_granted,
    output logic [fpba_pkg::ENTRY_IDX_W-1:0]    o_block_index,
    output logic [fpba_pkg::FIELD_SIZE_W-1:0]   o_block_size,
    output logic [fpba_pkg::FIELD_SIZE_W-1:0]   o_leftover
);
    import fpba_pkg::*;

    // Size table and per-block used flags.
    logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_used;

    // Configuration registers.
    logic [1:0]          r_fit_mode;
    logic [CNT_BITS-1:0] r_block_count;

    // Request context latched at start.
    t_fit_mode           r_mode;
    logic [SIZE_BITS-1:0] r_req;
    logic [CNT_BITS-1:0] r_count;
    logic                r_eop;

    // Scan pointer and registered table read.
    logic [CNT_BITS-1:0]  r_addr;
    logic [CNT_BITS-1:0]  n_addr;
    logic [SIZE_BITS-1:0] r_rd_data;

    // Best candidate so far.
    logic                 r_found;
    logic [IDX_BITS-1:0]  r_best_idx;
    logic [SIZE_BITS-1:0] r_best_size;

    // Output register.
    logic                    r_out_valid;
    logic                    r_granted;
    logic [ENTRY_IDX_W-1:0]  r_block_index;
    logic [FIELD_SIZE_W-1:0] r_block_size;
    logic [FIELD_SIZE_W-1:0] r_leftover;

    logic                cand;
    logic                take;
    logic                load_in_range;
    logic [CNT_BITS-1:0] cfg_count;
    logic [CNT_BITS-1:0] addr_inc;
    logic [SIZE_BITS-1:0] diff;

    // Configuration writes; a count above the table depth saturates.
    always_comb begin
        if (CNT_BITS'(i_cfg_data) > CNT_BITS'(NUM_BLOCKS)) begin
            cfg_count = CNT_BITS'(NUM_BLOCKS);
        end else begin
            cfg_count = CNT_BITS'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= FIT_FIRST;
            r_block_count <= CNT_BITS'(NUM_BLOCKS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIT_MODE:    r_fit_mode    <= i_cfg_data[1:0];
                CFG_BLOCK_COUNT: r_block_count <= cfg_count;
                default: begin
                end
            endcase
        end
    end

    // Table write; loads beyond the table depth are dropped.
    assign load_in_range = ({1'b0, i_entry_index} < (ENTRY_IDX_W + 1)'(NUM_BLOCKS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_in_range) begin
            mem[i_entry_index[IDX_BITS-1:0]] <= SIZE_BITS'(i_entry_size);
        end
        r_rd_data <= mem[n_addr[IDX_BITS-1:0]];
    end

    // Scan pointer; the read address is the next pointer so data lines up.
    assign addr_inc = r_addr + CNT_BITS'(1);

    always_comb begin
        if (i_cmd.start) begin
            n_addr = '0;
        end else if (i_cmd.step) begin
            n_addr = addr_inc;
        end else begin
            n_addr = r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    // Request context; the meaningless fourth mode code acts as first fit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            unique case (r_fit_mode)
                FIT_BEST:  r_mode <= FIT_BEST;
                FIT_WORST: r_mode <= FIT_WORST;
                default:   r_mode <= FIT_FIRST;
            endcase
            r_req   <= SIZE_BITS'(i_request_size);
            r_count <= r_block_count;
            r_eop   <= i_end_of_pass;
        end
    end

    // Candidate test and replacement rule; ties keep the lower index.
    assign cand = !r_used[r_addr[IDX_BITS-1:0]] && (r_rd_data >= r_req);

    always_comb begin
        take = 1'b0;
        if (cand) begin
            if (!r_found) begin
                take = 1'b1;
            end else begin
                case (r_mode)
                    FIT_BEST:  take = (r_rd_data < r_best_size);
                    FIT_WORST: take = (r_rd_data > r_best_size);
                    default:   take = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_found <= 1'b0;
        end else if (i_cmd.step && take) begin
            r_found     <= 1'b1;
            r_best_idx  <= r_addr[IDX_BITS-1:0];
            r_best_size <= r_rd_data;
        end
    end

    // Status back to the sequencer.
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.scan_done  = (addr_inc >= r_count) || ((r_mode == FIT_FIRST) && cand);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // Used flags: a publish marks the granted block, or frees them all on an end of pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.out_load) begin
            if (r_eop) begin
                r_used <= '0;
            end else if (r_found) begin
                r_used[r_best_idx] <= 1'b1;
            end
        end
    end

    // Output register; refused requests report zero fields.
    assign diff = r_best_size - r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_granted <= r_found;
            if (r_found) begin
                r_block_index <= ENTRY_IDX_W'(r_best_idx);
                r_block_size  <= FIELD_SIZE_W'(r_best_size);
                r_leftover    <= FIELD_SIZE_W'(diff);
            end else begin
                r_block_index <= '0;
                r_block_size  <= '0;
                r_leftover    <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_granted;
    assign o_block_index = r_block_index;
    assign o_block_size  = r_block_size;
    assign o_leftover    = r_leftover;

endmodule

// ===== rtl/fpba_checker.sv =====
// Port-level checker for the fit policy block allocator, bound to the top.
// Depends on the macros header and fpba_pkg.
`include "fit_policy_block_allocator_macros.svh"

module fpba_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_opcode,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_granted,
    input logic [fpba_pkg::ENTRY_IDX_W-1:0]    o_block_index,
    input logic [fpba_pkg::FIELD_SIZE_W-1:0]   o_block_size,
    input logic [fpba_pkg::FIELD_SIZE_W-1:0]   o_leftover
);
    import fpba_pkg::*;

    // A held result keeps its payload.
    `FPBA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_granted) && $stable(o_block_index) && $stable(o_block_size) && $stable(o_leftover))

    // A refused request reports all zero fields.
    `FPBA_ASSERT(a_refused_zero, i_clk, i_rst_n, o_out_valid && !o_granted |-> o_block_index == '0 && o_block_size == '0 && o_leftover == '0)

    // An accepted allocate blocks the input while the table is scanned.
    `FPBA_ASSERT(a_alloc_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_opcode == OP_ALLOC |=> o_in_stall)

    // Reset empties the output register.
    `FPBA_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_opcode      (i_opcode),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_granted     (o_granted),
    .o_block_index (o_block_index),
    .o_block_size  (o_block_size),
    .o_leftover    (o_leftover)
);
